/* src/lztd_pkg.sv */
package lztd_pkg;

  // History ring geometry.
  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = 12;
  localparam int FILL_W     = 13;

  // Token field widths and saturation limits.
  localparam int OFF_W = 17;
  localparam int LEN_W = 7;
  localparam logic [OFF_W-1:0] OFF_SAT = '1;
  localparam logic [LEN_W-1:0] LEN_SAT = '1;

  // Depth of the command queue between the parser and the copy engine.
  localparam int QDEPTH = 4;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_OFFSET = 2'd1;
  localparam logic [1:0] ST_TOO_LONG   = 2'd2;
  localparam logic [1:0] ST_NO_LENGTH  = 2'd3;

  typedef enum logic [1:0] {
    MODE_LIT = 2'd0,
    MODE_OFF = 2'd1,
    MODE_LEN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_ERR  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         data;
    logic [1:0]         status;
    logic [HIST_AW-1:0] offset;
    logic [LEN_W-1:0]   length;
  } cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_COPY = 1'b1
  } back_state_t;

endpackage

/* src/lztd_enc_if.sv */
interface lztd_enc_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* src/lztd_dec_if.sv */
interface lztd_dec_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

/* src/lz77_text_token_decoder.sv */
// Text-form LZ77 decoder.
//
// The enc channel carries one request per encoded byte. Non-digit bytes
// outside a token are literals; a token is decimal offset digits, one
// separator byte, decimal length digits and one terminator byte. The dec
// channel returns one request per decoded byte, or a single error request
// with a nonzero status and a zero byte for a malformed token. The final
// request caused by an input byte has last set.
//
// The parser takes one byte per cycle as long as its four-entry command
// queue has room. The copy engine reads a copy byte by byte through the
// single read port of the 4096-byte history memory and takes no new command
// until the copy is done. With nothing queued ahead of it, a literal goes
// from a queue slot into the output register and from there onto dec.
//
// Reset clears the parser, the queue, the write pointer and the output
// valid flag. The history memory is not cleared; offsets beyond the bytes
// stored so far are rejected. When the receiver holds dec.ready low, the
// output register holds its request, the copy engine stops, the queue fills
// and enc.ready then drops.
module lz77_text_token_decoder #(
  parameter int WINDOW   = 4096,
  parameter int MAX_COPY = 64
) (
  input  logic        clk,
  input  logic        rst,
  lztd_enc_if.sink    enc,
  lztd_dec_if.source  dec
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  lztd_pkg::cmd_t q_in;
  lztd_pkg::cmd_t q_head;

  // Parser: tracks token state and the number of history bytes, and turns
  // each literal byte or token into a literal, error or copy command.
  lztd_front #(
    .WINDOW   (WINDOW),
    .MAX_COPY (MAX_COPY)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .enc    (enc),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  // Short command queue so the parser and copy engine stall independently.
  lztd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Copy engine: owns the history memory and the output register.
  lztd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .dec     (dec)
  );

endmodule

/* src/lztd_ram.sv */
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/lztd_front.sv */
module lztd_front #(
  parameter int WINDOW   = 4096,
  parameter int MAX_COPY = 64
) (
  input  logic            clk,
  input  logic            rst,
  lztd_enc_if.sink        enc,
  input  logic            q_full,
  output logic            q_push,
  output lztd_pkg::cmd_t  q_cmd
);

  localparam logic [lztd_pkg::OFF_W-1:0] WIN_LIM = lztd_pkg::OFF_W'(WINDOW);
  localparam logic [lztd_pkg::LEN_W-1:0] LEN_LIM = lztd_pkg::LEN_W'(MAX_COPY);

  lztd_pkg::mode_t                mode, mode_next;
  logic [lztd_pkg::OFF_W-1:0]     offset_accum, offset_accum_next;
  logic [lztd_pkg::LEN_W-1:0]     length_accum, length_accum_next;
  logic                           length_seen, length_seen_next;
  logic [lztd_pkg::FILL_W-1:0]    fill_count, fill_count_next;

  logic                           take;
  logic                           digit;
  logic [3:0]                     dval;
  logic [20:0]                    off_prod;
  logic [10:0]                    len_prod;
  logic [lztd_pkg::FILL_W-1:0]    fill_sum;

  assign enc.ready = !q_full;
  assign take      = enc.valid && !q_full;
  assign digit     = enc.in_byte inside {[lztd_pkg::CHAR_ZERO:lztd_pkg::CHAR_NINE]};
  assign dval      = digit ? enc.in_byte[3:0] : 4'd0;
  assign off_prod  = 21'(offset_accum) * 21'd10 + 21'(dval);
  assign len_prod  = 11'(length_accum) * 11'd10 + 11'(dval);

  always_comb begin
    mode_next         = mode;
    offset_accum_next = offset_accum;
    length_accum_next = length_accum;
    length_seen_next  = length_seen;
    fill_count_next   = fill_count;
    q_push            = 1'b0;
    q_cmd.kind        = lztd_pkg::CMD_LIT;
    q_cmd.data        = enc.in_byte;
    q_cmd.status      = lztd_pkg::ST_OK;
    q_cmd.offset      = offset_accum[lztd_pkg::HIST_AW-1:0];
    q_cmd.length      = length_accum;
    fill_sum          = fill_count + lztd_pkg::FILL_W'(length_accum);

    if (take) begin
      case (mode)
        lztd_pkg::MODE_OFF: begin
          if (digit) begin
            offset_accum_next = (off_prod > 21'(lztd_pkg::OFF_SAT)) ?
                                lztd_pkg::OFF_SAT : off_prod[lztd_pkg::OFF_W-1:0];
          end else begin
            mode_next = lztd_pkg::MODE_LEN;
          end
        end
        lztd_pkg::MODE_LEN: begin
          if (digit) begin
            length_accum_next = (len_prod > 11'(lztd_pkg::LEN_SAT)) ?
                                lztd_pkg::LEN_SAT : len_prod[lztd_pkg::LEN_W-1:0];
            length_seen_next  = 1'b1;
          end else begin
            // Terminator: check the token and always fall back to literal mode.
            q_cmd.data = 8'd0;
            if (!length_seen) begin
              q_push       = 1'b1;
              q_cmd.kind   = lztd_pkg::CMD_ERR;
              q_cmd.status = lztd_pkg::ST_NO_LENGTH;
            end else if (offset_accum == '0 ||
                         offset_accum > lztd_pkg::OFF_W'(fill_count) ||
                         offset_accum > WIN_LIM) begin
              q_push       = 1'b1;
              q_cmd.kind   = lztd_pkg::CMD_ERR;
              q_cmd.status = lztd_pkg::ST_BAD_OFFSET;
            end else if (length_accum > LEN_LIM) begin
              q_push       = 1'b1;
              q_cmd.kind   = lztd_pkg::CMD_ERR;
              q_cmd.status = lztd_pkg::ST_TOO_LONG;
            end else begin
              // A zero-length copy produces nothing.
              q_push          = (length_accum != '0);
              q_cmd.kind      = lztd_pkg::CMD_COPY;
              fill_count_next = (fill_sum > lztd_pkg::FILL_W'(lztd_pkg::HIST_DEPTH)) ?
                                lztd_pkg::FILL_W'(lztd_pkg::HIST_DEPTH) : fill_sum;
            end
            mode_next         = lztd_pkg::MODE_LIT;
            offset_accum_next = '0;
            length_accum_next = '0;
            length_seen_next  = 1'b0;
          end
        end
        default: begin
          if (digit) begin
            mode_next         = lztd_pkg::MODE_OFF;
            offset_accum_next = lztd_pkg::OFF_W'(dval);
            length_accum_next = '0;
            length_seen_next  = 1'b0;
          end else begin
            mode_next = lztd_pkg::MODE_LIT;
            q_push    = 1'b1;
            if (fill_count != lztd_pkg::FILL_W'(lztd_pkg::HIST_DEPTH)) begin
              fill_count_next = fill_count + 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= lztd_pkg::MODE_LIT;
      offset_accum <= '0;
      length_accum <= '0;
      length_seen  <= 1'b0;
      fill_count   <= '0;
    end else begin
      mode         <= mode_next;
      offset_accum <= offset_accum_next;
      length_accum <= length_accum_next;
      length_seen  <= length_seen_next;
      fill_count   <= fill_count_next;
    end
  end

endmodule

/* src/lztd_queue.sv */
module lztd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lztd_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lztd_pkg::cmd_t  head
);

  localparam int AW = $clog2(lztd_pkg::QDEPTH);

  lztd_pkg::cmd_t slots [lztd_pkg::QDEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full  = (count == (AW+1)'(lztd_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/lztd_back.sv */
module lztd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  lztd_pkg::cmd_t  q_head,
  output logic            q_pop,
  lztd_dec_if.source      dec
);

  localparam int AW = lztd_pkg::HIST_AW;

  lztd_pkg::back_state_t  state, state_next;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          src;
  logic [lztd_pkg::LEN_W-1:0] rd_left;
  logic [lztd_pkg::LEN_W-1:0] wr_left;
  logic                   pend;
  logic                   fwd_sel;
  logic [7:0]             fwd_data;
  logic                   out_valid;
  logic [7:0]             out_byte;
  logic [1:0]             out_status;
  logic                   out_last;

  logic                   can_load;
  logic                   load;
  logic [7:0]             ld_byte;
  logic [1:0]             ld_status;
  logic                   ld_last;
  logic                   we;
  logic                   re;
  logic [7:0]             wdata;
  logic [7:0]             ram_rdata;
  logic [7:0]             rd_byte;
  logic                   start_copy;

  lztd_ram #(
    .WIDTH (8),
    .DEPTH (lztd_pkg::HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (wdata),
    .re    (re),
    .raddr (src),
    .rdata (ram_rdata)
  );

  // A read of the entry written in the same cycle takes the new byte.
  assign rd_byte  = fwd_sel ? fwd_data : ram_rdata;
  assign can_load = !out_valid || dec.ready;

  always_comb begin
    state_next = state;
    case (state)
      lztd_pkg::BK_IDLE: begin
        if (!q_empty && q_head.kind == lztd_pkg::CMD_COPY) begin
          state_next = lztd_pkg::BK_COPY;
        end
      end
      lztd_pkg::BK_COPY: begin
        if (pend && can_load && wr_left == lztd_pkg::LEN_W'(1)) begin
          state_next = lztd_pkg::BK_IDLE;
        end
      end
      default: state_next = lztd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    start_copy = 1'b0;
    load       = 1'b0;
    ld_byte    = 8'd0;
    ld_status  = lztd_pkg::ST_OK;
    ld_last    = 1'b1;
    we         = 1'b0;
    wdata      = q_head.data;
    re         = 1'b0;
    case (state)
      lztd_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.kind == lztd_pkg::CMD_COPY) begin
            q_pop      = 1'b1;
            start_copy = 1'b1;
          end else if (can_load) begin
            q_pop     = 1'b1;
            load      = 1'b1;
            ld_status = q_head.status;
            if (q_head.kind == lztd_pkg::CMD_LIT) begin
              ld_byte = q_head.data;
              we      = 1'b1;
            end
          end
        end
      end
      lztd_pkg::BK_COPY: begin
        if (pend && can_load) begin
          load    = 1'b1;
          ld_byte = rd_byte;
          ld_last = (wr_left == lztd_pkg::LEN_W'(1));
          we      = 1'b1;
          wdata   = rd_byte;
        end
        re = (rd_left != '0) && (!pend || can_load);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (re) begin
      fwd_sel  <= we && (src == wp);
      fwd_data <= wdata;
    end
    if (start_copy) begin
      src     <= wp - q_head.offset;
      rd_left <= q_head.length;
      wr_left <= q_head.length;
    end else begin
      if (re) begin
        src     <= src + 1'b1;
        rd_left <= rd_left - 1'b1;
      end
      if (load && state == lztd_pkg::BK_COPY) begin
        wr_left <= wr_left - 1'b1;
      end
    end
    if (load) begin
      out_byte   <= ld_byte;
      out_status <= ld_status;
      out_last   <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lztd_pkg::BK_IDLE;
      wp        <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        wp <= wp + 1'b1;
      end
      if (re) begin
        pend <= 1'b1;
      end else if (load && state == lztd_pkg::BK_COPY) begin
        pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (dec.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign dec.valid    = out_valid;
  assign dec.out_byte = out_byte;
  assign dec.status   = out_status;
  assign dec.last     = out_last;

endmodule

/* dv/lz77_text_token_decoder_tb.sv */
// Self-checking bench for the text-form LZ77 token decoder.
//
// Encoded bytes go in on the enc channel, one request per byte. A predictor in
// this module follows the parser and the history ring byte by byte. Each time
// a request is accepted, the predictor queues the decoded requests that the
// block must return for that byte. Every request on the dec channel is
// compared field by field against the oldest queued entry.
//
// The run has two parts. A short table of directed bytes comes first: extreme
// literals, every error code, an overlapping copy and a zero-length copy.
// Random traffic follows: runs of literals and well-formed tokens with random
// offsets, lengths and delimiters, mixed with malformed tokens and raw noise.
module lz77_text_token_decoder_tb;

  localparam int WINDOW   = 4096;
  localparam int MAX_COPY = 64;

  // Least number of random encoded bytes to send after the directed table.
  localparam int RANDOM_BYTES = 323;
  // Idle probability, in percent, on either side of the block.
  localparam int IDLE_PCT = 18;
  // Enough cycles for a full-length copy to drain after the last request.
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } decoded_result_t;

  // A directed row is one encoded byte. A row whose expected request can be
  // read off directly carries that request. Other rows leave it to the
  // predictor.
  typedef struct packed {
    logic [7:0]      code;
    logic            typed;
    decoded_result_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [27] = '{
    // Literals right after reset, including both extreme byte values.
    '{8'h00, 1'b1, '{8'h00, lztd_pkg::ST_OK, 1'b1}},
    '{8'hFF, 1'b1, '{8'hFF, lztd_pkg::ST_OK, 1'b1}},
    '{"A",   1'b1, '{"A",   lztd_pkg::ST_OK, 1'b1}},
    // Offset 9 reaches past the three bytes that are stored so far.
    '{"9",   1'b0, '0},
    '{" ",   1'b0, '0},
    '{"1",   1'b0, '0},
    '{"!",   1'b1, '{8'h00, lztd_pkg::ST_BAD_OFFSET, 1'b1}},
    // Offset zero. The delimiters sit just below and above the digit range.
    '{"0",   1'b0, '0},
    '{"/",   1'b0, '0},
    '{"1",   1'b0, '0},
    '{":",   1'b1, '{8'h00, lztd_pkg::ST_BAD_OFFSET, 1'b1}},
    // A terminator arrives right after the separator, so there is no length.
    '{"1",   1'b0, '0},
    '{"@",   1'b0, '0},
    '{";",   1'b1, '{8'h00, lztd_pkg::ST_NO_LENGTH, 1'b1}},
    // A length of one past the copy limit.
    '{"1",   1'b0, '0},
    '{",",   1'b0, '0},
    '{"6",   1'b0, '0},
    '{"5",   1'b0, '0},
    '{".",   1'b1, '{8'h00, lztd_pkg::ST_TOO_LONG, 1'b1}},
    // An overlapping copy: four bytes from three back wrap onto themselves.
    '{"3",   1'b0, '0},
    '{",",   1'b0, '0},
    '{"4",   1'b0, '0},
    '{"x",   1'b0, '0},
    // A valid token of length zero, which returns nothing.
    '{"2",   1'b0, '0},
    '{",",   1'b0, '0},
    '{"0",   1'b0, '0},
    '{"\n",  1'b0, '0}
  };

  logic clk;
  logic rst;

  lztd_enc_if enc_ch();
  lztd_dec_if dec_ch();

  lz77_text_token_decoder #(
    .WINDOW   (WINDOW),
    .MAX_COPY (MAX_COPY)
  ) uut (
    .clk (clk),
    .rst (rst),
    .enc (enc_ch),
    .dec (dec_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predictor state. It mirrors the parser and the history ring of the block.
  lztd_pkg::mode_t              p_mode;
  logic [lztd_pkg::OFF_W-1:0]   p_off;
  logic [lztd_pkg::LEN_W-1:0]   p_len;
  logic                         p_seen;
  logic [7:0]                   p_hist [lztd_pkg::HIST_DEPTH];
  logic [lztd_pkg::HIST_AW-1:0] p_wr;
  logic [lztd_pkg::FILL_W-1:0]  p_fill;

  decoded_result_t byte_results[$];   // requests caused by the byte just decoded
  decoded_result_t decoded_due[$];    // requests still owed by the block

  int  mismatches = 0;
  int  bytes_sent = 0;
  // While calm is set, neither side of the block idles.
  bit  calm = 1'b0;

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(255));
    while (b >= lztd_pkg::CHAR_ZERO && b <= lztd_pkg::CHAR_NINE);
    return b;
  endfunction

  function automatic void store_hist(input logic [7:0] c);
    p_hist[p_wr] = c;
    p_wr = p_wr + 1'b1;
    if (p_fill < lztd_pkg::FILL_W'(lztd_pkg::HIST_DEPTH))
      p_fill = p_fill + 1'b1;
  endfunction

  function automatic void note_result(input logic [7:0] d, input logic [1:0] st,
                                      input logic lst);
    decoded_result_t r;
    r = '{d, st, lst};
    byte_results = {byte_results, r};
  endfunction

  function automatic void clear_token();
    p_mode = lztd_pkg::MODE_LIT;
    p_off  = '0;
    p_len  = '0;
    p_seen = 1'b0;
  endfunction

  // Decodes one encoded byte and leaves the requests it causes in byte_results.
  function automatic void decode_byte(input logic [7:0] b);
    logic                         is_digit;
    logic [3:0]                   d;
    int unsigned                  acc;
    logic [lztd_pkg::HIST_AW-1:0] src;
    logic [7:0]                   c;
    is_digit = (b >= lztd_pkg::CHAR_ZERO) && (b <= lztd_pkg::CHAR_NINE);
    d = is_digit ? 4'(b - lztd_pkg::CHAR_ZERO) : 4'd0;
    byte_results.delete();
    case (p_mode)
      lztd_pkg::MODE_OFF: begin
        if (is_digit) begin
          acc = p_off * 10 + d;
          p_off = (acc > lztd_pkg::OFF_SAT) ? lztd_pkg::OFF_SAT : lztd_pkg::OFF_W'(acc);
        end else begin
          // The separator is swallowed, and the length field starts.
          p_mode = lztd_pkg::MODE_LEN;
        end
      end
      lztd_pkg::MODE_LEN: begin
        if (is_digit) begin
          acc = p_len * 10 + d;
          p_len = (acc > lztd_pkg::LEN_SAT) ? lztd_pkg::LEN_SAT : lztd_pkg::LEN_W'(acc);
          p_seen = 1'b1;
        end else begin
          // A terminator ends the token. The error checks come in a fixed order.
          if (!p_seen) begin
            note_result(8'h00, lztd_pkg::ST_NO_LENGTH, 1'b1);
          end else if (p_off == '0 || p_off > p_fill || p_off > WINDOW) begin
            note_result(8'h00, lztd_pkg::ST_BAD_OFFSET, 1'b1);
          end else if (p_len > MAX_COPY) begin
            note_result(8'h00, lztd_pkg::ST_TOO_LONG, 1'b1);
          end else begin
            // An offset of a full ring wraps to the write pointer itself.
            src = p_wr - p_off[lztd_pkg::HIST_AW-1:0];
            for (int i = 0; i < p_len; i++) begin
              c = p_hist[src];
              store_hist(c);
              src = src + 1'b1;
              note_result(c, lztd_pkg::ST_OK, i == p_len - 1);
            end
          end
          clear_token();
        end
      end
      default: begin
        if (is_digit) begin
          p_mode = lztd_pkg::MODE_OFF;
          p_off  = lztd_pkg::OFF_W'(d);
          p_len  = '0;
          p_seen = 1'b0;
        end else begin
          store_hist(b);
          note_result(b, lztd_pkg::ST_OK, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s, got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sends one encoded byte. The task returns in the time step of the edge that
  // accepts the request. Only then does the predictor see the byte. A typed
  // row replaces the requests that the predictor gives with its own.
  task automatic send_request(input logic [7:0] b, input logic typed,
                              input decoded_result_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      enc_ch.valid <= 1'b0;
      @(posedge clk);
    end
    enc_ch.valid   <= 1'b1;
    enc_ch.in_byte <= b;
    do
      @(posedge clk);
    while (!enc_ch.ready);
    decode_byte(b);
    if (typed)
      decoded_due = {decoded_due, want};
    else
      decoded_due = {decoded_due, byte_results};
    bytes_sent++;
  endtask

  // Writes a number in decimal, with a leading zero now and then.
  task automatic send_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0)
      s = {"0", s};
    for (int i = 0; i < s.len(); i++)
      send_request(s[i], 1'b0, '0);
  endtask

  task automatic send_random_digits(input int n);
    repeat (n) send_request(8'(lztd_pkg::CHAR_ZERO + $urandom_range(9)), 1'b0, '0);
  endtask

  // One random unit of the stream: a run of literals, a good copy token, a
  // token that is often malformed, or raw noise. The noise can begin tokens of its own.
  task automatic send_random_unit();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    if (pick < 30 || p_fill == '0) begin
      repeat ($urandom_range(1, 6)) send_request(plain_byte(), 1'b0, '0);
    end else if (pick < 70) begin
      // Short offsets dominate, so that overlapping copies are common.
      if (p_fill > 24 && $urandom_range(3) == 0)
        span = p_fill;
      else
        span = (p_fill < 16) ? p_fill : 16;
      send_number($urandom_range(1, span));
      send_request(plain_byte(), 1'b0, '0);
      case ($urandom_range(9))
        0:       send_number(0);
        1:       send_number(MAX_COPY);
        2, 3:    send_number($urandom_range(13, MAX_COPY));
        default: send_number($urandom_range(1, 12));
      endcase
      send_request(plain_byte(), 1'b0, '0);
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0:       send_number(0);
        1:       send_number(p_fill + $urandom_range(1, 5000));
        // Long digit strings usually run past the window and can saturate.
        2:       send_random_digits($urandom_range(5, 9));
        default: send_number($urandom_range(1, p_fill));
      endcase
      send_request(plain_byte(), 1'b0, '0);
      case ($urandom_range(3))
        0:       ;  // no length digits at all
        1:       send_number($urandom_range(MAX_COPY + 1, 127));
        2:       send_random_digits($urandom_range(3, 6));
        default: send_number($urandom_range(1, 8));
      endcase
      send_request(plain_byte(), 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 4)) send_request(8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  // The receiver stalls at random, except during the calm stretch.
  always @(posedge clk)
    dec_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  // Each accepted dec request is checked against the oldest owed request.
  always @(posedge clk) begin
    decoded_result_t exp;
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      if (decoded_due.size() == 0) begin
        report_mismatch("request with nothing owed", dec_ch.out_byte, 8'h00);
      end else begin
        exp = decoded_due.pop_front();
        if (dec_ch.out_byte !== exp.data)
          report_mismatch("out_byte", dec_ch.out_byte, exp.data);
        if (dec_ch.status !== exp.status)
          report_mismatch("status", 8'(dec_ch.status), 8'(exp.status));
        if (dec_ch.last !== exp.last)
          report_mismatch("last", 8'(dec_ch.last), 8'(exp.last));
      end
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;
    rst            <= 1'b1;
    enc_ch.valid   <= 1'b0;
    enc_ch.in_byte <= 8'h00;
    p_wr   = '0;
    p_fill = '0;
    clear_token();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_request(DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].want);

    while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
      // Hold the sender once until the block has returned everything it owes.
      // The queue then drains completely, and the next byte meets an empty pipe.
      if (!drained && bytes_sent >= 120) begin
        enc_ch.valid <= 1'b0;
        do
          @(posedge clk);
        while (decoded_due.size() != 0);
        drained = 1'b1;
      end
      calm <= (bytes_sent >= 220) && (bytes_sent < 300);
      send_random_unit();
    end
    enc_ch.valid <= 1'b0;
    calm <= 1'b0;

    while (decoded_due.size() != 0)
      @(posedge clk);
    // Any extra request from the block would appear within a full copy time.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && decoded_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
